// File: hdl/lsvc_pkg.sv
package lsvc_pkg;

  localparam int COORD_BITS = 16;
  localparam int CELL_BITS  = 8;

  // Remainder pipeline: bits of the coordinate retired per stage.
  localparam int MOD_STEP   = 4;
  localparam int MOD_STAGES = (COORD_BITS + MOD_STEP - 1) / MOD_STEP;
  localparam int PAD_BITS   = MOD_STAGES * MOD_STEP;

  // Remainder stages, then distance, square, sum and compare stages.
  localparam int NUM_STAGES = MOD_STAGES + 4;

  localparam int SQ_BITS  = 2 * CELL_BITS;
  localparam int SUM_BITS = 2 * CELL_BITS + 2;
  localparam int CMP_BITS = SUM_BITS + 2;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = CELL_BITS;

  typedef logic [CELL_BITS-1:0]      cell_t;
  typedef logic [COORD_BITS-1:0]     coord_t;
  typedef logic [PAD_BITS-1:0]       pad_t;
  typedef logic [SQ_BITS-1:0]        sq_t;
  typedef logic [SUM_BITS-1:0]       sum_t;
  typedef logic [CMP_BITS-1:0]       cmp_t;
  typedef logic [1:0]                mode_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

  localparam mode_t MODE_SC  = 2'd0;
  localparam mode_t MODE_BCC = 2'd1;
  localparam mode_t MODE_FCC = 2'd2;

  localparam cfg_index_t REG_LATTICE_MODE = 1'd0;
  localparam cfg_index_t REG_CELL_SIZE    = 1'd1;

  localparam mode_t RESET_MODE = MODE_SC;
  localparam cell_t RESET_CELL = cell_t'(8);

endpackage

// File: hdl/lattice_sphere_voxel_classifier.sv
// Channel   Handshake                  Payload
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
// voxel in  in_valid / in_stall        pos_x, pos_y, pos_z
// result    out_valid / out_stall      solid
//
// One voxel enters per cycle while in_stall is low; its result is offered
// behind NUM_STAGES stages: MOD_STAGES remainder stages plus four more.
// Reset clears all valid bits and restores the simple cubic mode with cell 8.
// A stall at the output fills bubbles first, then holds every stage in place.
module lattice_sphere_voxel_classifier (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  lsvc_pkg::cfg_index_t       cfg_index,
  input  lsvc_pkg::cfg_data_t        cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lsvc_pkg::coord_t           pos_x,
  input  lsvc_pkg::coord_t           pos_y,
  input  lsvc_pkg::coord_t           pos_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       solid
);

  localparam int MS = lsvc_pkg::MOD_STAGES;
  localparam int NS = lsvc_pkg::NUM_STAGES;
  localparam int ST = lsvc_pkg::MOD_STEP;
  localparam int PB = lsvc_pkg::PAD_BITS;
  localparam int CB = lsvc_pkg::CELL_BITS;

  function automatic lsvc_pkg::cell_t mod_chunk(input lsvc_pkg::cell_t r_in,
                                                input logic [ST-1:0] bits,
                                                input lsvc_pkg::cell_t a);
    logic [CB:0] t;
    lsvc_pkg::cell_t r;
    r = r_in;
    for (int j = ST - 1; j >= 0; j--) begin
      t = {r, bits[j]};
      if (t >= {1'b0, a}) begin
        t = t - {1'b0, a};
      end
      r = t[CB-1:0];
    end
    return r;
  endfunction

  function automatic lsvc_pkg::sq_t square(input lsvc_pkg::cell_t v);
    lsvc_pkg::sq_t ve;
    ve = lsvc_pkg::sq_t'(v);
    return lsvc_pkg::sq_t'(ve * ve);
  endfunction

  function automatic lsvc_pkg::sum_t sum3(input lsvc_pkg::sq_t u,
                                          input lsvc_pkg::sq_t v,
                                          input lsvc_pkg::sq_t w);
    return lsvc_pkg::sum_t'(u) + lsvc_pkg::sum_t'(v) + lsvc_pkg::sum_t'(w);
  endfunction

  lsvc_pkg::mode_t lattice_mode;
  lsvc_pkg::cell_t cell_size;
  lsvc_pkg::cell_t a_eff;
  lsvc_pkg::sq_t   aa;

  logic [NS-1:0] vld;
  logic [NS-1:0] go;

  lsvc_pkg::pad_t  pin   [3];
  lsvc_pkg::pad_t  crd   [MS-1][3];
  lsvc_pkg::cell_t rem   [MS][3];
  lsvc_pkg::cell_t rem_next [MS][3];

  lsvc_pkg::cell_t cd  [3];
  lsvc_pkg::cell_t hd  [3];
  lsvc_pkg::cell_t cd_next [3];
  lsvc_pkg::cell_t hd_next [3];
  lsvc_pkg::sq_t   csq [3];
  lsvc_pkg::sq_t   hsq [3];

  lsvc_pkg::sum_t q_c, q_b, q_f1, q_f2, q_f3;
  logic           solid_next;

  assign cfg_ready = 1'b1;
  assign a_eff     = (cell_size == '0) ? lsvc_pkg::cell_t'(1) : cell_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_mode <= lsvc_pkg::RESET_MODE;
      cell_size    <= lsvc_pkg::RESET_CELL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lsvc_pkg::REG_LATTICE_MODE: lattice_mode <= cfg_data[1:0];
        lsvc_pkg::REG_CELL_SIZE:    cell_size    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    aa <= square(a_eff);
  end

  // Bubble-collapsing flow control: a stage loads when it is empty or drains.
  always_comb begin
    go[NS-1] = !vld[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      go[k] = !vld[k] || go[k+1];
    end
  end

  assign in_stall  = !go[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (go[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign pin[0] = lsvc_pkg::pad_t'(pos_x);
  assign pin[1] = lsvc_pkg::pad_t'(pos_y);
  assign pin[2] = lsvc_pkg::pad_t'(pos_z);

  // Restoring remainder, most significant coordinate bits first.
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      rem_next[0][ax] = mod_chunk('0, pin[ax][PB-1 -: ST], a_eff);
      for (int k = 1; k < MS; k++) begin
        rem_next[k][ax] = mod_chunk(rem[k-1][ax], crd[k-1][ax][PB-1-k*ST -: ST], a_eff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      for (int ax = 0; ax < 3; ax++) begin
        crd[0][ax] <= pin[ax];
        rem[0][ax] <= rem_next[0][ax];
      end
    end
    for (int k = 1; k < MS - 1; k++) begin
      if (go[k]) begin
        for (int ax = 0; ax < 3; ax++) begin
          crd[k][ax] <= crd[k-1][ax];
        end
      end
    end
    for (int k = 1; k < MS; k++) begin
      if (go[k]) begin
        for (int ax = 0; ax < 3; ax++) begin
          rem[k][ax] <= rem_next[k][ax];
        end
      end
    end
  end

  // Doubled distances to the nearest corner and to the centre plane.
  always_comb begin
    logic [CB:0]   m2;
    logic [CB:0]   a9;
    logic [CB+1:0] two_a;
    for (int ax = 0; ax < 3; ax++) begin
      m2    = {rem[MS-1][ax], 1'b0};
      a9    = {1'b0, a_eff};
      two_a = {1'b0, a_eff, 1'b0};
      if (m2 <= a9) begin
        cd_next[ax] = m2[CB-1:0];
      end else begin
        cd_next[ax] = lsvc_pkg::cell_t'(two_a - {1'b0, m2});
      end
      if (m2 >= a9) begin
        hd_next[ax] = lsvc_pkg::cell_t'(m2 - a9);
      end else begin
        hd_next[ax] = lsvc_pkg::cell_t'(a9 - m2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[MS]) begin
      for (int ax = 0; ax < 3; ax++) begin
        cd[ax] <= cd_next[ax];
        hd[ax] <= hd_next[ax];
      end
    end
    if (go[MS+1]) begin
      for (int ax = 0; ax < 3; ax++) begin
        csq[ax] <= square(cd[ax]);
        hsq[ax] <= square(hd[ax]);
      end
    end
    if (go[MS+2]) begin
      q_c  <= sum3(csq[0], csq[1], csq[2]);
      q_b  <= sum3(hsq[0], hsq[1], hsq[2]);
      q_f1 <= sum3(hsq[0], hsq[1], csq[2]);
      q_f2 <= sum3(hsq[0], csq[1], hsq[2]);
      q_f3 <= sum3(csq[0], hsq[1], hsq[2]);
    end
    if (go[MS+3]) begin
      solid <= solid_next;
    end
  end

  always_comb begin
    lsvc_pkg::cmp_t aa_e;
    lsvc_pkg::cmp_t aa3;
    aa_e = lsvc_pkg::cmp_t'(aa);
    aa3  = aa_e + (aa_e << 1);
    case (lattice_mode)
      lsvc_pkg::MODE_SC: begin
        solid_next = lsvc_pkg::cmp_t'(q_c) <= aa_e;
      end
      lsvc_pkg::MODE_BCC: begin
        solid_next = ((lsvc_pkg::cmp_t'(q_c) << 2) <= aa3)
                  || ((lsvc_pkg::cmp_t'(q_b) << 2) <= aa3);
      end
      lsvc_pkg::MODE_FCC: begin
        solid_next = ((lsvc_pkg::cmp_t'(q_c)  << 1) <= aa_e)
                  || ((lsvc_pkg::cmp_t'(q_f1) << 1) <= aa_e)
                  || ((lsvc_pkg::cmp_t'(q_f2) << 1) <= aa_e)
                  || ((lsvc_pkg::cmp_t'(q_f3) << 1) <= aa_e);
      end
      default: begin
        solid_next = 1'b0;
      end
    endcase
  end

endmodule

// File: sim/tb_lattice_sphere_voxel_classifier.sv
`timescale 1ns / 1ps

module tb_lattice_sphere_voxel_classifier;

  localparam lsvc_pkg::mode_t MODE_NONE = 2'd3;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct {
    lsvc_pkg::coord_t x;
    lsvc_pkg::coord_t y;
    lsvc_pkg::coord_t z;
    logic             solid;
  } voxel_verdict_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  lsvc_pkg::cfg_index_t cfg_index;
  lsvc_pkg::cfg_data_t  cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  lsvc_pkg::coord_t     pos_x;
  lsvc_pkg::coord_t     pos_y;
  lsvc_pkg::coord_t     pos_z;
  logic                 out_valid;
  logic                 out_stall;
  logic                 solid;

  lsvc_pkg::mode_t mode_now = lsvc_pkg::RESET_MODE;
  lsvc_pkg::cell_t cell_now = lsvc_pkg::RESET_CELL;
  voxel_verdict_t  pending_verdicts[$];
  int unsigned     in_gap_pct = 0;
  int unsigned     stall_pct = 0;
  int unsigned     stall_left = 0;
  int unsigned     voxels_sent = 0;
  int unsigned     solid_expected = 0;
  int unsigned     reg_writes = 0;
  int unsigned     mismatches = 0;

  lattice_sphere_voxel_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .solid     (solid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned corner_span(lsvc_pkg::coord_t p, int unsigned a);
    int unsigned m2;
    m2 = 2 * (p % a);
    return (m2 <= a) ? m2 : (2 * a - m2);
  endfunction

  function automatic int unsigned centre_span(lsvc_pkg::coord_t p, int unsigned a);
    int unsigned m2;
    m2 = 2 * (p % a);
    return (m2 >= a) ? (m2 - a) : (a - m2);
  endfunction

  function automatic int unsigned square_sum(int unsigned u, int unsigned v, int unsigned w);
    return u * u + v * v + w * w;
  endfunction

  function automatic logic predict_solid(lsvc_pkg::mode_t mode, lsvc_pkg::cell_t cell_sz,
                                         lsvc_pkg::coord_t x, lsvc_pkg::coord_t y,
                                         lsvc_pkg::coord_t z);
    int unsigned a, aa, cx, cy, cz, hx, hy, hz;
    a  = (cell_sz == 0) ? 1 : cell_sz;
    aa = a * a;
    cx = corner_span(x, a);
    cy = corner_span(y, a);
    cz = corner_span(z, a);
    hx = centre_span(x, a);
    hy = centre_span(y, a);
    hz = centre_span(z, a);
    case (mode)
      lsvc_pkg::MODE_SC:  return square_sum(cx, cy, cz) <= aa;
      lsvc_pkg::MODE_BCC: return (4 * square_sum(cx, cy, cz) <= 3 * aa) ||
                                 (4 * square_sum(hx, hy, hz) <= 3 * aa);
      lsvc_pkg::MODE_FCC: return (2 * square_sum(cx, cy, cz) <= aa) ||
                                 (2 * square_sum(hx, hy, cz) <= aa) ||
                                 (2 * square_sum(hx, cy, hz) <= aa) ||
                                 (2 * square_sum(cx, hy, hz) <= aa);
      default:            return 1'b0;
    endcase
  endfunction

  function automatic int unsigned pick_gap(int unsigned pct);
    if (pct == 0 || $urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // Most coordinates land close to a corner or a cell centre, where the
  // sphere surfaces lie; the rest are uniform over the whole range.
  function automatic lsvc_pkg::coord_t pick_coord();
    int unsigned a, base;
    a = (cell_now == 0) ? 1 : cell_now;
    if ($urandom_range(9) < 4) return lsvc_pkg::coord_t'($urandom);
    base = ($urandom_range(65535) / a) * a;
    if ($urandom_range(1) == 1) base += a / 2;
    return lsvc_pkg::coord_t'(base + $urandom_range(4) - 2);
  endfunction

  task automatic send_voxel(input lsvc_pkg::coord_t x, input lsvc_pkg::coord_t y,
                            input lsvc_pkg::coord_t z);
    voxel_verdict_t v;
    int unsigned gap;
    gap = pick_gap(in_gap_pct);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    pos_z    <= z;
    do @(posedge clk); while (in_stall);
    v.x     = x;
    v.y     = y;
    v.z     = z;
    v.solid = predict_solid(mode_now, cell_now, x, y, z);
    pending_verdicts.push_back(v);
    voxels_sent++;
    if (v.solid) solid_expected++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input lsvc_pkg::cfg_index_t idx, input lsvc_pkg::cfg_data_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == lsvc_pkg::REG_LATTICE_MODE) begin
      mode_now = lsvc_pkg::mode_t'(data[1:0]);
    end else begin
      cell_now = data;
    end
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_values();
    send_voxel(16'd0, 16'd0, 16'd0);
    send_voxel(16'd4, 16'd4, 16'd4);
    send_voxel(16'd65535, 16'd65535, 16'd65535);
    send_voxel(16'd0, 16'd65535, 16'd32768);
    send_voxel(16'd4, 16'd0, 16'd0);
  endtask

  task automatic test_directed_corners();
    drain_results();
    write_reg(lsvc_pkg::REG_LATTICE_MODE, {6'h3F, lsvc_pkg::MODE_BCC});
    send_voxel(16'd4, 16'd4, 16'd4);
    send_voxel(16'd2, 16'd2, 16'd2);
    send_voxel(16'd1, 16'd1, 16'd1);
    send_voxel(16'd3, 16'd3, 16'd0);
    drain_results();
    write_reg(lsvc_pkg::REG_LATTICE_MODE, lsvc_pkg::cfg_data_t'(lsvc_pkg::MODE_FCC));
    send_voxel(16'd4, 16'd4, 16'd0);
    send_voxel(16'd4, 16'd0, 16'd4);
    send_voxel(16'd0, 16'd4, 16'd4);
    send_voxel(16'd2, 16'd2, 16'd2);
    send_voxel(16'd65535, 16'd65535, 16'd65535);
    drain_results();
    write_reg(lsvc_pkg::REG_LATTICE_MODE, {6'h3F, MODE_NONE});
    send_voxel(16'd0, 16'd0, 16'd0);
    send_voxel(16'd4, 16'd4, 16'd4);
    drain_results();
    write_reg(lsvc_pkg::REG_LATTICE_MODE, lsvc_pkg::cfg_data_t'(lsvc_pkg::MODE_SC));
    write_reg(lsvc_pkg::REG_CELL_SIZE, 8'd0);
    send_voxel(16'd12345, 16'd65535, 16'd7);
    send_voxel(16'd0, 16'd0, 16'd0);
    drain_results();
    write_reg(lsvc_pkg::REG_LATTICE_MODE, lsvc_pkg::cfg_data_t'(lsvc_pkg::MODE_BCC));
    write_reg(lsvc_pkg::REG_CELL_SIZE, 8'd255);
    send_voxel(16'd65535, 16'd65535, 16'd65535);
    send_voxel(16'd127, 16'd128, 16'd127);
    send_voxel(16'd63, 16'd64, 16'd64);
    drain_results();
    write_reg(lsvc_pkg::REG_LATTICE_MODE, lsvc_pkg::cfg_data_t'(lsvc_pkg::MODE_FCC));
    write_reg(lsvc_pkg::REG_CELL_SIZE, 8'd1);
    send_voxel(16'd1, 16'd2, 16'd3);
    drain_results();
    write_reg(lsvc_pkg::REG_LATTICE_MODE, lsvc_pkg::cfg_data_t'(lsvc_pkg::MODE_SC));
    write_reg(lsvc_pkg::REG_CELL_SIZE, 8'd6);
    send_voxel(16'd65535, 16'd32767, 16'd3);
  endtask

  task automatic test_drain_pause();
    drain_results();
    write_reg(lsvc_pkg::REG_LATTICE_MODE, lsvc_pkg::cfg_data_t'(lsvc_pkg::MODE_BCC));
    write_reg(lsvc_pkg::REG_CELL_SIZE, 8'd12);
    in_gap_pct = 20;
    stall_pct  = 20;
    repeat (20) send_voxel(pick_coord(), pick_coord(), pick_coord());
    drain_results();
    repeat (20) send_voxel(pick_coord(), pick_coord(), pick_coord());
  endtask

  task automatic test_random_sweep();
    lsvc_pkg::cell_t cells[12] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd16, 8'd31,
                                   8'd100, 8'd128, 8'd254, 8'd255};
    int unsigned     gap_pcts[4] = '{0, 15, 40, 70};
    int unsigned     stall_pcts[4] = '{0, 60, 25, 8};
    lsvc_pkg::mode_t m;
    lsvc_pkg::cell_t c;
    for (int p = 0; p < 14; p++) begin
      drain_results();
      if (p < 12) begin
        m = lsvc_pkg::mode_t'(p % 3);
        c = cells[p];
      end else begin
        m = lsvc_pkg::mode_t'($urandom_range(3));
        c = lsvc_pkg::cell_t'($urandom_range(255));
      end
      write_reg(lsvc_pkg::REG_LATTICE_MODE,
                lsvc_pkg::cfg_data_t'(($urandom_range(63) << 2) | m));
      write_reg(lsvc_pkg::REG_CELL_SIZE, c);
      in_gap_pct = gap_pcts[p % 4];
      stall_pct  = stall_pcts[(p / 2) % 4];
      repeat (90) send_voxel(pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        stall_left = pick_gap(stall_pct);
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    voxel_verdict_t v;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result transfer, solid %0b", $time, solid);
        mismatches++;
      end else begin
        v = pending_verdicts.pop_front();
        if (solid !== v.solid) begin
          $display("%0t: voxel (%0d,%0d,%0d) solid expected %0b, actual %0b",
                   $time, v.x, v.y, v.z, v.solid, solid);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("tb_lattice_sphere_voxel_classifier: errors");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    pos_x     = '0;
    pos_y     = '0;
    pos_z     = '0;
    cfg_valid = 1'b0;
    cfg_index = lsvc_pkg::REG_LATTICE_MODE;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_corners();
    test_drain_pause();
    test_random_sweep();
    drain_results();
    repeat (4 * lsvc_pkg::NUM_STAGES) @(posedge clk);
    $display("Classified %0d voxels, %0d of them solid, across %0d register writes",
             voxels_sent, solid_expected, reg_writes);
    $display("covering all four lattice modes and cell sizes from 0 to 255.");
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("tb_lattice_sphere_voxel_classifier: clean");
    end else begin
      $display("tb_lattice_sphere_voxel_classifier: errors");
    end
    $finish;
  end

endmodule
